// ===== hw/rtl/pulse_width_symbol_sender_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse width symbol sender
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_SYMBOL_SENDER_ASSERT_SVH
`define PULSE_WIDTH_SYMBOL_SENDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check an implication on every clock edge outside reset
`define PWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// check a condition that must hold in the cycle after a trigger
`define PWS_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`else

`define PWS_ASSERT(lbl, prop, msg)
`define PWS_ASSERT_NEXT(lbl, trig, prop, msg)

`endif

`endif

// ===== hw/rtl/pws_pkg.sv =====
// ----------------------------------------------------------------------------
// pws_pkg
// Types and constants of the pulse width symbol sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pws_pkg;

	localparam int LINE_COUNT = 3;
	// data line vector, at least as wide as the three output lines
	localparam int LEVEL_W    = (LINE_COUNT > 3) ? LINE_COUNT : 3;
	localparam int SYM_W      = 6;
	localparam int SYM_EXT_W  = 2 * LEVEL_W;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int FIELD_W    = 2;

	localparam logic [CFG_W-1:0] PERIOD_RST = 24'd50000;
	localparam logic [CFG_W-1:0] SHORT_RST  = 24'd12500;
	localparam logic [CFG_W-1:0] MIDDLE_RST = 24'd25000;
	localparam logic [CFG_W-1:0] LONG_RST   = 24'd37500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD      = 2'd0,
		CFG_DUTY_SHORT  = 2'd1,
		CFG_DUTY_MIDDLE = 2'd2,
		CFG_DUTY_LONG   = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LEAD  = 2'd1,
		PH_SYM   = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	typedef enum logic [FIELD_W-1:0] {
		FIELD_OFF    = 2'd0,
		FIELD_SHORT  = 2'd1,
		FIELD_MIDDLE = 2'd2,
		FIELD_LONG   = 2'd3
	} field_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_OFFER = 1'b1
	} op_t;

	typedef struct packed {
		logic             operation;
		logic [SYM_W-1:0] symbol;
		logic             opens_frame;
		logic             closes_frame;
	} in_word_t;

	typedef struct packed {
		logic clock_line;
		logic red_line;
		logic green_line;
		logic blue_line;
		logic ready_res;
		logic accepted;
	} out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pulse_width_symbol_sender.sv =====
// ----------------------------------------------------------------------------
// pulse_width_symbol_sender
// Drives key codes as pulse widths on three active-low lines with a framing
// clock line; each input word is a tick or a symbol offer.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   in_word  (operation, symbol, frame flags)
//   output    out_valid / out_ready out_word (line levels, ready, accepted)
//   config    wr_en                 wr_index, wr_data
//
// One word per cycle while the output is not stalled; a word waits in the
// input register and then passes to the result register.
// The per-word work is one 24-bit increment and compare against the period
// plus the duty compares, all between the input and result registers.
// Reset clears the phase, counter and valid flags and loads the default period
// and duties. A stalled output holds its word; the input register then fills
// and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_width_symbol_sender_assert.svh"

module pulse_width_symbol_sender (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pws_pkg::in_word_t            in_word,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pws_pkg::out_word_t                out_word,
	input  wire logic                         wr_en,
	input  wire logic [pws_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [pws_pkg::CFG_W-1:0]    wr_data
);
	import pws_pkg::*;

	// configuration
	logic [CFG_W-1:0] period_q;
	logic [CFG_W-1:0] duty_short_q;
	logic [CFG_W-1:0] duty_middle_q;
	logic [CFG_W-1:0] duty_long_q;

	// input stage
	logic     valid_s1;
	in_word_t word_s1;

	// sender state
	phase_t           phase_q;
	logic [CFG_W-1:0] elapsed_q;
	logic [FIELD_W-1:0] fields_q [LINE_COUNT];
	logic             trail_q;

	// result register
	logic      out_valid_q;
	out_word_t out_word_q;

	// next state and result
	phase_t             phase_n;
	logic [CFG_W-1:0]   elapsed_n;
	logic [FIELD_W-1:0] fields_n [LINE_COUNT];
	logic               trail_n;
	logic               acc_n;
	logic [CFG_W:0]     el_inc;
	logic [CFG_W-1:0]   per_eff;
	logic               wrap;
	logic [SYM_EXT_W-1:0] sym_ext;
	logic [LEVEL_W-1:0] data_lv;
	logic               clock_lv;
	logic [CFG_W-1:0]   duty_sel;
	logic               advance;
	out_word_t          result;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= PERIOD_RST;
			duty_short_q  <= SHORT_RST;
			duty_middle_q <= MIDDLE_RST;
			duty_long_q   <= LONG_RST;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				CFG_PERIOD:      period_q      <= wr_data;
				CFG_DUTY_SHORT:  duty_short_q  <= wr_data;
				CFG_DUTY_MIDDLE: duty_middle_q <= wr_data;
				CFG_DUTY_LONG:   duty_long_q   <= wr_data;
				default:         period_q      <= period_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_comb begin
		per_eff   = (period_q == '0) ? CFG_W'(1) : period_q;
		el_inc    = {1'b0, elapsed_q} + (CFG_W + 1)'(1);
		wrap      = el_inc >= {1'b0, per_eff};
		sym_ext   = SYM_EXT_W'(word_s1.symbol);
		phase_n   = phase_q;
		elapsed_n = elapsed_q;
		trail_n   = trail_q;
		acc_n     = 1'b0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			fields_n[i] = fields_q[i];
		end
		if (op_t'(word_s1.operation) == OP_OFFER) begin
			if (phase_q == PH_IDLE) begin
				for (int i = 0; i < LINE_COUNT; i++) begin
					fields_n[i] = sym_ext[FIELD_W*i +: FIELD_W];
				end
				trail_n   = word_s1.closes_frame;
				elapsed_n = '0;
				phase_n   = word_s1.opens_frame ? PH_LEAD : PH_SYM;
				acc_n     = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			elapsed_n = el_inc[CFG_W-1:0];
			if (wrap) begin
				elapsed_n = '0;
				case (phase_q)
					PH_LEAD: phase_n = PH_SYM;
					PH_SYM: begin
						// go through the trailing clock period if the frame closes here
						if (trail_q) begin
							trail_n = 1'b0;
							phase_n = PH_TRAIL;
						end else begin
							phase_n = PH_IDLE;
						end
					end
					default: phase_n = PH_IDLE;
				endcase
			end
		end
	end

	// line levels after this word
	always_comb begin
		clock_lv = !(((phase_n == PH_LEAD) || (phase_n == PH_TRAIL))
			&& (elapsed_n < duty_middle_q));
		data_lv  = '1;
		duty_sel = '0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			case (field_t'(fields_n[i]))
				FIELD_SHORT:  duty_sel = duty_short_q;
				FIELD_MIDDLE: duty_sel = duty_middle_q;
				FIELD_LONG:   duty_sel = duty_long_q;
				default:      duty_sel = '0;
			endcase
			if (phase_n == PH_SYM && elapsed_n < duty_sel) begin
				data_lv[i] = 1'b0;
			end
		end
		result.clock_line = clock_lv;
		result.red_line   = data_lv[0];
		result.green_line = data_lv[1];
		result.blue_line  = data_lv[2];
		result.ready_res  = (phase_n == PH_IDLE);
		result.accepted   = acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			trail_q   <= 1'b0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				fields_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q   <= phase_n;
			elapsed_q <= elapsed_n;
			trail_q   <= trail_n;
			for (int i = 0; i < LINE_COUNT; i++) begin
				fields_q[i] <= fields_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= result;
		end
	end

	`PWS_ASSERT(a_idle_counter_clear, (phase_q == PH_IDLE) |-> (elapsed_q == '0), "counter not clear in idle")
	`PWS_ASSERT(a_trail_consumed, (phase_q == PH_TRAIL) |-> !trail_q, "trailing flag left set in trailing period")
	`PWS_ASSERT(a_accept_busy, (out_valid_q && out_word_q.accepted) |-> !out_word_q.ready_res, "accepted word reports ready")
	`PWS_ASSERT(a_idle_lines_high, (out_valid_q && out_word_q.ready_res) |-> (out_word_q.clock_line && out_word_q.red_line && out_word_q.green_line && out_word_q.blue_line), "line low while idle")
	`PWS_ASSERT_NEXT(a_offer_busy, (advance && (op_t'(word_s1.operation) == OP_OFFER) && (phase_q != PH_IDLE)), !out_word_q.accepted, "offer taken while busy")

endmodule

`default_nettype wire

// ===== verif/pulse_width_symbol_sender_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_symbol_sender_tb
// Self-checking bench for the pulse width symbol sender. A directed table
// covers reset levels, refused offers, zero and oversized duties and a zero
// period. Random words then run under a series of register settings. Each
// result is checked per field against the table or a cycle-free line model.
// Sender bursts, receiver stalls and a long output hold-off vary the timing.
// ----------------------------------------------------------------------------

module pulse_width_symbol_sender_tb;
	import pws_pkg::*;

	localparam int                ITEMS_PER_SETTING = 135;
	localparam int                N_SETTINGS        = 12;
	localparam int                HOLD_CYCLES       = 80;
	localparam int                LIMIT_NS          = 3_000_000;
	localparam logic [CFG_W-1:0]  MAX24             = 24'hFFFFFF;

	typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;
	typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE } stall_t;

	typedef struct {
		row_kind_t  kind;
		in_word_t   w;
		cfg_index_t idx;
		logic [CFG_W-1:0] val;
		bit         typed;
		out_word_t  want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_word;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_W-1:0]      wr_data;

	pulse_width_symbol_sender DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line model state and its copy of the registers
	phase_t           line_phase;
	logic [24:0]      line_elapsed;
	field_t           line_field [3];
	logic             line_trailing;
	logic [CFG_W-1:0] reg_period, reg_short, reg_middle, reg_long;
	bit               line_moved;

	out_word_t        pending_levels [$];
	int               mismatches = 0;
	int               hold_requests = 0;
	int               hold_served = 0;
	int               hold_left = 0;
	int               rx_cycle = 0;
	stall_t           stall_mode = RX_OPEN;
	int               burst_left = 0;
	bit               no_gaps = 1'b0;
	string            field_names [6] = '{"clock_line", "red_line", "green_line",
		"blue_line", "ready_res", "accepted"};

	task automatic note_mismatch(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic logic [CFG_W-1:0] duty_for(field_t f);
		case (f)
			FIELD_SHORT:  return reg_short;
			FIELD_MIDDLE: return reg_middle;
			FIELD_LONG:   return reg_long;
			default:      return '0;
		endcase
	endfunction

	// advance the line model by one word and return the levels after it
	function automatic out_word_t advance_lines(in_word_t w);
		logic [24:0] span;
		logic        took;
		out_word_t   r;
		took = 1'b0;
		line_moved = 1'b0;
		if (w.operation == OP_OFFER) begin
			if (line_phase == PH_IDLE) begin
				line_field[0] = field_t'(w.symbol[1:0]);
				line_field[1] = field_t'(w.symbol[3:2]);
				line_field[2] = field_t'(w.symbol[5:4]);
				line_trailing = w.closes_frame;
				line_elapsed = '0;
				line_phase = w.opens_frame ? PH_LEAD : PH_SYM;
				took = 1'b1;
				line_moved = 1'b1;
			end
		end else if (line_phase != PH_IDLE) begin
			line_moved = 1'b1;
			span = (reg_period == '0) ? 25'd1 : {1'b0, reg_period};
			line_elapsed = line_elapsed + 25'd1;
			if (line_elapsed >= span) begin
				line_elapsed = '0;
				case (line_phase)
					PH_LEAD: line_phase = PH_SYM;
					PH_SYM: begin
						if (line_trailing) begin
							line_trailing = 1'b0;
							line_phase = PH_TRAIL;
						end else begin
							line_phase = PH_IDLE;
						end
					end
					default: line_phase = PH_IDLE;
				endcase
			end
		end
		r.clock_line = !((line_phase == PH_LEAD || line_phase == PH_TRAIL) &&
			line_elapsed < {1'b0, reg_middle});
		r.red_line   = !(line_phase == PH_SYM && line_field[0] != FIELD_OFF &&
			line_elapsed < {1'b0, duty_for(line_field[0])});
		r.green_line = !(line_phase == PH_SYM && line_field[1] != FIELD_OFF &&
			line_elapsed < {1'b0, duty_for(line_field[1])});
		r.blue_line  = !(line_phase == PH_SYM && line_field[2] != FIELD_OFF &&
			line_elapsed < {1'b0, duty_for(line_field[2])});
		r.ready_res  = (line_phase == PH_IDLE);
		r.accepted   = took;
		return r;
	endfunction

	function automatic stim_row_t word_row(op_t op, logic [SYM_W-1:0] sym, logic opens,
		logic closes, bit typed, logic [5:0] want);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.w.operation = op;
		r.w.symbol = sym;
		r.w.opens_frame = opens;
		r.w.closes_frame = closes;
		r.idx = CFG_PERIOD;
		r.val = '0;
		r.typed = typed;
		r.want = out_word_t'(want);
		return r;
	endfunction

	function automatic stim_row_t cfg_row(cfg_index_t idx, logic [CFG_W-1:0] val);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.w = '0;
		r.idx = idx;
		r.val = val;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_duty(logic [CFG_W-1:0] per);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return MAX24;
			default: return (per > 64) ? CFG_W'($urandom_range(0, 64)) :
				CFG_W'($urandom_range(0, per + 2));
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.symbol = SYM_W'($urandom_range(0, 63));
		w.opens_frame = 1'($urandom_range(0, 1));
		w.closes_frame = 1'($urandom_range(0, 1));
		// offer mostly when idle, tick mostly when busy
		if (line_phase == PH_IDLE) begin
			w.operation = ($urandom_range(0, 7) != 0) ? OP_OFFER : OP_TICK;
		end else begin
			w.operation = ($urandom_range(0, 9) == 0) ? OP_OFFER : OP_TICK;
		end
		return w;
	endfunction

	// drop valid and wait until every result word is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_levels.size() != 0);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_PERIOD:      reg_period = v;
			CFG_DUTY_SHORT:  reg_short = v;
			CFG_DUTY_MIDDLE: reg_middle = v;
			default:         reg_long = v;
		endcase
		@(posedge clk);
	endtask

	task automatic send_word(in_word_t w, bit typed, out_word_t want, output bit moved);
		int        gap;
		out_word_t r;
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		r = advance_lines(w);
		pending_levels.push_back(typed ? want : r);
		moved = line_moved;
	endtask

	// receiver: check result words, then pick next ready level
	always @(posedge clk) begin
		out_word_t want;
		if (out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				note_mismatch($sformatf("result word %b with nothing pending", out_word));
			end else begin
				want = pending_levels.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (out_word[5-i] !== want[5-i]) begin
						note_mismatch($sformatf("%s got %b want %b", field_names[i],
							out_word[5-i], want[5-i]));
					end
				end
			end
		end
		rx_cycle++;
		if (rx_cycle % 64 == 0) stall_mode = stall_t'($urandom_range(0, 3));
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
				RX_COMB:  out_ready <= (rx_cycle % 4 != 0);
				default:  out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("FAIL pulse_width_symbol_sender");
		$finish;
	end

	initial begin
		stim_row_t        rows [$];
		logic [CFG_W-1:0] per;
		int               done;
		int               budget;
		bit               moved;
		bit               paused;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		line_phase = PH_IDLE;
		line_elapsed = '0;
		foreach (line_field[i]) line_field[i] = FIELD_OFF;
		line_trailing = 1'b0;
		reg_period = PERIOD_RST;
		reg_short = SHORT_RST;
		reg_middle = MIDDLE_RST;
		reg_long = LONG_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// levels are {clock, red, green, blue, ready, accepted}
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));
		rows.push_back(word_row(OP_OFFER, 6'h3F, 1, 1, 1, 6'b011101));
		rows.push_back(word_row(OP_OFFER, 6'h15, 0, 0, 1, 6'b011100));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b011100));
		rows.push_back(cfg_row(CFG_PERIOD, 24'd1));
		rows.push_back(word_row(OP_TICK,  6'h3F, 1, 1, 1, 6'b100000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b011100));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));
		// zero short duty, long duty beyond the period
		rows.push_back(cfg_row(CFG_PERIOD, 24'd2));
		rows.push_back(cfg_row(CFG_DUTY_SHORT, 24'd0));
		rows.push_back(cfg_row(CFG_DUTY_MIDDLE, 24'd1));
		rows.push_back(cfg_row(CFG_DUTY_LONG, MAX24));
		rows.push_back(word_row(OP_OFFER, 6'h39, 0, 1, 1, 6'b110001));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 1, 1, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));
		rows.push_back(word_row(OP_OFFER, 6'h2A, 1, 0, 1, 6'b011101));
		rows.push_back(word_row(OP_OFFER, 6'h00, 0, 0, 1, 6'b011100));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 0, 6'b000000));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));
		// zero period runs as one tick
		rows.push_back(cfg_row(CFG_PERIOD, 24'd0));
		rows.push_back(word_row(OP_OFFER, 6'h17, 1, 1, 1, 6'b011101));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b101100));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b011100));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));
		rows.push_back(word_row(OP_OFFER, 6'h00, 0, 0, 1, 6'b111101));
		rows.push_back(word_row(OP_TICK,  6'h00, 0, 0, 1, 6'b111110));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_word(rows[i].w, rows[i].typed, rows[i].want, moved);
			end
		end

		for (int p = 0; p < N_SETTINGS; p++) begin
			case (p)
				0:       per = MAX24;
				3:       per = 24'd1;
				default: per = CFG_W'($urandom_range(0, 12));
			endcase
			drain();
			write_reg(CFG_PERIOD, per);
			write_reg(CFG_DUTY_SHORT,  (p == 1) ? '0 : (p == 2) ? MAX24 : pick_duty(per));
			write_reg(CFG_DUTY_MIDDLE, (p == 1) ? '0 : (p == 2) ? MAX24 : pick_duty(per));
			write_reg(CFG_DUTY_LONG,   (p == 1) ? '0 : (p == 2) ? MAX24 : pick_duty(per));
			no_gaps = (p == 3) || (p % 4 == 1);
			// hold the output off while words keep coming
			if (p == 3) hold_requests <= hold_requests + 1;
			budget = (p == 0) ? 40 : ITEMS_PER_SETTING;
			done = 0;
			paused = 1'b0;
			while (done < budget) begin
				if (p == 5 && !paused && done >= budget / 2) begin
					drain();
					paused = 1'b1;
				end
				send_word(random_word(), 1'b0, '0, moved);
				if (moved) done++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_levels.size() == 0) begin
			$display("PASS pulse_width_symbol_sender");
		end else begin
			$display("FAIL pulse_width_symbol_sender");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pws_pkg.sv
hw/rtl/pulse_width_symbol_sender.sv
verif/pulse_width_symbol_sender_tb.sv
